### design/mpt_pkg.sv
`default_nettype none
package mpt_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_RESULTS      = 62;
    localparam int RES_CNT_W        = 6;
    localparam int IDX_OUT_W        = 6;
    localparam int COORD_W          = 16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DEGEN    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [4:0] {
        CMD_LOAD,
        CMD_CHECK,
        CMD_SCAN_RD,
        CMD_SCAN_CMP,
        CMD_SCAN_END,
        CMD_MERGE_RD,
        CMD_MERGE_CMP,
        CMD_STK_INIT,
        CMD_SW_P,
        CMD_SW_P2,
        CMD_SW_P3,
        CMD_POP1,
        CMD_POP2,
        CMD_POP3,
        CMD_RD_F,
        CMD_RD_S,
        CMD_RD_PV,
        CMD_RD_AV,
        CMD_DIFF,
        CMD_MUL,
        CMD_ORIENT,
        CMD_NOP,
        CMD_CUT,
        CMD_PUSH_S,
        CMD_PUSH_F,
        CMD_PUSH_L,
        CMD_PUSH_P,
        CMD_DONE,
        CMD_FLUSH
    } t_cmd;

    typedef struct packed {
        logic acc_last;
        logic ovf;
        logic few;
        logic scan_last;
        logic flat;
        logic tri3;
        logic merge_last;
        logic deep;
        logic ok;
        logic same;
        logic empty;
        logic p_last;
        logic stall;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

### design/monotone_polygon_triangulator_top.sv
// Triangulates a y-monotone polygon given as integer vertices in boundary order.
// Input stream: one vertex per transaction, tdata = {vy, vx}, tlast on the final
// vertex. Vertices load at one per cycle; tready is low from the final vertex
// until the polygon's last result has been placed in the output register.
// Output stream: one transaction per triangle, tdata = {status, below, top, new}
// and tlast on the last result of the polygon; errors give a single result.
// After the final vertex the block scans the store for the vertices of highest
// and lowest y and merges the two rails between them into one sweep order.
// The sweep then takes the vertices in that order; each orientation test reads
// the store, multiplies and compares, then emits a triangle or pushes back.
// The next polygon is accepted only after the sweep of this one has finished.
// One finished triangle is held back so that tlast can mark the last one;
// the output register and this holding slot decouple the sweep from the
// receiver, which may stall at any time; the sweep waits only when both are
// full. Synchronous active-low reset empties the vertex store count, the
// stack and both result slots and returns the block to loading.
`default_nettype none
module monotone_polygon_triangulator_top
    import mpt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // vx [15:0], vy [31:16]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,  // new [5:0], top [11:6], below [17:12], status [19:18]
    output logic        m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    assign s_axis_tready = cmd == CMD_LOAD;

    mpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mpt_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .i_s_tdata  (s_axis_tdata),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready)
    );

endmodule
`default_nettype wire

### design/mpt_ctrl.sv
`default_nettype none
module mpt_ctrl
    import mpt_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_LOAD, S_CHECK, S_SRD, S_SCMP, S_SCHK, S_MRD, S_MCMP, S_SINIT,
        S_SP, S_SP2, S_SP3, S_L1, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7, S_L8,
        S_L9, S_L10, S_L11, S_CUT, S_PUSH_SC, S_PUSH_S, S_PUSH_F, S_END,
        S_PUSH_L, S_PUSH_P, S_DONE, S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        unique case (r_state)
            S_LOAD: begin
                o_cmd = CMD_LOAD;
                if (i_sts.acc_last) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd   = CMD_CHECK;
                n_state = (i_sts.ovf || i_sts.few) ? S_FLUSH : S_SRD;
            end
            S_SRD: begin
                o_cmd   = CMD_SCAN_RD;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                o_cmd   = CMD_SCAN_CMP;
                n_state = i_sts.scan_last ? S_SCHK : S_SRD;
            end
            S_SCHK: begin
                o_cmd   = CMD_SCAN_END;
                n_state = (i_sts.flat || i_sts.tri3) ? S_FLUSH : S_MRD;
            end
            S_MRD: begin
                o_cmd   = CMD_MERGE_RD;
                n_state = S_MCMP;
            end
            S_MCMP: begin
                o_cmd   = CMD_MERGE_CMP;
                n_state = i_sts.merge_last ? S_SINIT : S_MRD;
            end
            S_SINIT: begin
                o_cmd   = CMD_STK_INIT;
                n_state = S_PUSH_P;
            end
            S_SP: begin
                o_cmd   = CMD_SW_P;
                n_state = S_SP2;
            end
            S_SP2: begin
                o_cmd   = CMD_SW_P2;
                n_state = S_SP3;
            end
            S_SP3: begin
                o_cmd   = CMD_SW_P3;
                n_state = S_L1;
            end
            S_L1: begin
                o_cmd   = CMD_POP1;
                n_state = i_sts.deep ? S_L2 : S_END;
            end
            S_L2: begin
                o_cmd   = CMD_POP2;
                n_state = S_L3;
            end
            S_L3: begin
                o_cmd   = CMD_POP3;
                n_state = S_L4;
            end
            S_L4: begin
                o_cmd   = CMD_RD_F;
                n_state = S_L5;
            end
            S_L5: begin
                o_cmd   = CMD_RD_S;
                n_state = S_L6;
            end
            S_L6: begin
                o_cmd   = CMD_RD_PV;
                n_state = S_L7;
            end
            S_L7: begin
                o_cmd   = CMD_RD_AV;
                n_state = S_L8;
            end
            S_L8: begin
                o_cmd   = CMD_DIFF;
                n_state = S_L9;
            end
            S_L9: begin
                o_cmd   = CMD_MUL;
                n_state = S_L10;
            end
            S_L10: begin
                o_cmd   = CMD_ORIENT;
                n_state = S_L11;
            end
            S_L11: begin
                o_cmd   = CMD_NOP;
                n_state = i_sts.ok ? S_CUT : S_PUSH_S;
            end
            S_CUT: begin
                o_cmd = CMD_CUT;
                if (!i_sts.stall) begin
                    n_state = (!i_sts.same && i_sts.empty) ? S_END : S_PUSH_SC;
                end
            end
            S_PUSH_SC: begin
                o_cmd   = CMD_PUSH_S;
                n_state = S_L1;
            end
            S_PUSH_S: begin
                o_cmd   = CMD_PUSH_S;
                n_state = S_PUSH_F;
            end
            S_PUSH_F: begin
                o_cmd   = CMD_PUSH_F;
                n_state = S_END;
            end
            S_END: begin
                o_cmd   = CMD_NOP;
                n_state = i_sts.same ? S_PUSH_P : S_PUSH_L;
            end
            S_PUSH_L: begin
                o_cmd   = CMD_PUSH_L;
                n_state = S_PUSH_P;
            end
            S_PUSH_P: begin
                o_cmd   = CMD_PUSH_P;
                n_state = i_sts.p_last ? S_DONE : S_SP;
            end
            S_DONE: begin
                o_cmd   = CMD_DONE;
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd = CMD_FLUSH;
                if (i_sts.out_free) n_state = S_LOAD;
            end
            default: begin
                o_cmd   = CMD_NOP;
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### design/mpt_datapath.sv
`default_nettype none
module mpt_datapath
    import mpt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  wire         i_s_tvalid,
    input  wire         i_s_tlast,
    input  wire  [31:0] i_s_tdata,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tvalid,
    input  wire         i_m_tready
);

    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 2);
    localparam int SCAP = 2 * MAX_VERTICES + 2;
    localparam int SAW  = $clog2(SCAP);
    localparam int DW   = $clog2(SCAP + 1);

    logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
    logic        [IW:0]        mem_sw [MAX_VERTICES];
    logic        [IW-1:0]      mem_stk [SCAP];

    logic signed [COORD_W-1:0] r_rx, r_ry, r_ry2;
    logic [IW:0]   r_rsw;
    logic [IW-1:0] r_rstk;
    logic [IW-1:0] addr_a, addr_b, addr_sw;
    logic [SAW-1:0] addr_stk;

    logic [CW-1:0] r_cnt, r_i, r_k, r_p, cnt_m1;
    logic [IW-1:0] r_up, r_lo, r_ri, r_li;
    logic signed [COORD_W-1:0] r_upy, r_loy;
    logic r_ldone;

    logic [IW-1:0] r_ip, r_last, r_f, r_s, r_if, r_is;
    logic r_sidep, r_same, r_ok;
    logic signed [COORD_W-1:0] r_px, r_py, r_ax, r_ay;
    logic signed [COORD_W:0] r_dax, r_day, r_dbx, r_dby;
    logic signed [2*COORD_W+1:0] r_m1, r_m2;
    logic signed [2*COORD_W+2:0] orient;

    logic [DW-1:0] r_depth, dm1, dm2;
    logic [RES_CNT_W-1:0] r_nres;

    logic r_pv, r_ov, r_ofin;
    logic [IDX_OUT_W-1:0] r_pn, r_pt, r_pb, r_on, r_ot, r_ob;
    logic [1:0] r_pst, r_ost;

    logic accept, out_free, stall, push, take_left, rdone, room, out_load;
    logic [IW-1:0] push_data;

    function automatic logic [IDX_OUT_W-1:0] to6(input logic [IW-1:0] v);
        logic [IW+IDX_OUT_W-1:0] e;
        e = {{IDX_OUT_W{1'b0}}, v};
        return e[IDX_OUT_W-1:0];
    endfunction

    assign cnt_m1   = r_cnt - CW'(1);
    assign dm1      = r_depth - DW'(1);
    assign dm2      = r_depth - DW'(2);
    assign accept   = (i_cmd == CMD_LOAD) && i_s_tvalid;
    assign out_free = !r_ov || i_m_tready;
    assign room     = r_nres < RES_CNT_W'(MAX_RESULTS);
    assign stall    = room && r_pv && !out_free;
    assign out_load = ((i_cmd == CMD_CUT) && room && !stall && r_pv)
                   || ((i_cmd == CMD_FLUSH) && out_free);
    assign rdone    = r_ri == r_lo;
    assign take_left = !r_ldone && (rdone || (r_ry > r_ry2));
    assign orient   = {r_m1[2*COORD_W+1], r_m1} - {r_m2[2*COORD_W+1], r_m2};

    always_comb begin
        push      = 1'b0;
        push_data = r_s;
        case (i_cmd)
            CMD_STK_INIT: begin
                push      = 1'b1;
                push_data = '0;
            end
            CMD_PUSH_S: push = 1'b1;
            CMD_PUSH_F: begin
                push      = 1'b1;
                push_data = r_f;
            end
            CMD_PUSH_L: begin
                push      = 1'b1;
                push_data = r_last;
            end
            CMD_PUSH_P: begin
                push      = 1'b1;
                push_data = r_p[IW-1:0];
            end
            default: push = 1'b0;
        endcase
    end

    always_comb begin
        addr_a   = '0;
        addr_b   = '0;
        addr_sw  = '0;
        addr_stk = '0;
        case (i_cmd)
            CMD_SCAN_RD: addr_a = r_i[IW-1:0];
            CMD_MERGE_RD: begin
                addr_a = r_li;
                addr_b = r_ri;
            end
            CMD_SW_P: begin
                addr_sw  = r_p[IW-1:0];
                addr_stk = dm1[SAW-1:0];
            end
            CMD_SW_P2: addr_sw  = r_rstk;
            CMD_POP1:  addr_stk = dm1[SAW-1:0];
            CMD_POP2:  addr_stk = dm2[SAW-1:0];
            CMD_POP3:  addr_sw  = r_f;
            CMD_RD_F:  addr_sw  = r_s;
            CMD_RD_S:  addr_a   = r_ip;
            CMD_RD_PV: addr_a   = r_if;
            CMD_RD_AV: addr_a   = r_is;
            default:   addr_a   = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_cnt < CW'(MAX_VERTICES))) begin
            mem_x[r_cnt[IW-1:0]] <= i_s_tdata[15:0];
            mem_y[r_cnt[IW-1:0]] <= i_s_tdata[31:16];
        end
        if (i_cmd == CMD_MERGE_CMP) begin
            mem_sw[r_k[IW-1:0]] <= take_left ? {1'b0, r_li} : {1'b1, r_ri};
        end
        if (push && (r_depth < DW'(SCAP))) begin
            mem_stk[r_depth[SAW-1:0]] <= push_data;
        end
        r_rx   <= mem_x[addr_a];
        r_ry   <= mem_y[addr_a];
        r_ry2  <= mem_y[addr_b];
        r_rsw  <= mem_sw[addr_sw];
        r_rstk <= mem_stk[addr_stk];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_CHECK: r_i <= '0;
            CMD_SCAN_CMP: begin
                r_i <= r_i + CW'(1);
                if (r_i == '0) begin
                    r_up  <= '0;
                    r_lo  <= '0;
                    r_upy <= r_ry;
                    r_loy <= r_ry;
                end else begin
                    if (r_ry > r_upy) begin
                        r_up  <= r_i[IW-1:0];
                        r_upy <= r_ry;
                    end
                    if (r_ry < r_loy) begin
                        r_lo  <= r_i[IW-1:0];
                        r_loy <= r_ry;
                    end
                end
            end
            CMD_SCAN_END: begin
                r_ri    <= r_up;
                r_li    <= (r_up == '0) ? cnt_m1[IW-1:0] : r_up - IW'(1);
                r_ldone <= 1'b0;
                r_k     <= '0;
            end
            CMD_MERGE_CMP: begin
                r_k <= r_k + CW'(1);
                if (take_left) begin
                    if (r_li == r_lo) r_ldone <= 1'b1;
                    else r_li <= (r_li == '0) ? cnt_m1[IW-1:0] : r_li - IW'(1);
                end else begin
                    r_ri <= (CW'(r_ri) == cnt_m1) ? '0 : r_ri + IW'(1);
                end
            end
            CMD_STK_INIT: r_p <= CW'(1);
            CMD_SW_P2: begin
                r_ip    <= r_rsw[IW-1:0];
                r_sidep <= r_rsw[IW];
                r_last  <= r_rstk;
            end
            CMD_SW_P3: r_same <= r_rsw[IW] == r_sidep;
            CMD_POP2:  r_f    <= r_rstk;
            CMD_POP3:  r_s    <= r_rstk;
            CMD_RD_F:  r_if   <= r_rsw[IW-1:0];
            CMD_RD_S:  r_is   <= r_rsw[IW-1:0];
            CMD_RD_PV: begin
                r_px <= r_rx;
                r_py <= r_ry;
            end
            CMD_RD_AV: begin
                r_ax <= r_rx;
                r_ay <= r_ry;
            end
            CMD_DIFF: begin
                r_dax <= {r_ax[COORD_W-1], r_ax} - {r_px[COORD_W-1], r_px};
                r_day <= {r_ay[COORD_W-1], r_ay} - {r_py[COORD_W-1], r_py};
                r_dbx <= {r_rx[COORD_W-1], r_rx} - {r_px[COORD_W-1], r_px};
                r_dby <= {r_ry[COORD_W-1], r_ry} - {r_py[COORD_W-1], r_py};
            end
            CMD_MUL: begin
                r_m1 <= r_dax * r_dby;
                r_m2 <= r_day * r_dbx;
            end
            CMD_ORIENT: begin
                if (r_same) r_ok <= r_sidep ? (orient > 0) : (orient < 0);
                else r_ok <= r_sidep ? (orient < 0) : (orient > 0);
            end
            CMD_PUSH_P: r_p <= r_p + CW'(1);
            default: r_i <= r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_depth <= '0;
            r_nres  <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_m_tready && !out_load) r_ov <= 1'b0;
            if (accept) begin
                r_cnt <= (r_cnt < CW'(MAX_VERTICES)) ? r_cnt + CW'(1)
                                                      : CW'(MAX_VERTICES + 1);
            end
            if (push && (r_depth < DW'(SCAP))) r_depth <= r_depth + DW'(1);
            case (i_cmd)
                CMD_CHECK: begin
                    r_nres <= '0;
                    r_pn   <= '0;
                    r_pt   <= '0;
                    r_pb   <= '0;
                    if (r_cnt > CW'(MAX_VERTICES)) begin
                        r_pv  <= 1'b1;
                        r_pst <= ST_OVERFLOW;
                    end else if (r_cnt < CW'(3)) begin
                        r_pv  <= 1'b1;
                        r_pst <= ST_DEGEN;
                    end
                end
                CMD_SCAN_END: begin
                    if (r_upy == r_loy) begin
                        r_pv  <= 1'b1;
                        r_pst <= ST_DEGEN;
                    end else if (r_cnt == CW'(3)) begin
                        r_pv  <= 1'b1;
                        r_pst <= ST_OK;
                        r_pt  <= IDX_OUT_W'(1);
                        r_pb  <= IDX_OUT_W'(2);
                    end
                end
                CMD_POP3: r_depth <= dm2;
                CMD_CUT: begin
                    if (room && !stall) begin
                        if (r_pv) begin
                            r_ov   <= 1'b1;
                            r_on   <= r_pn;
                            r_ot   <= r_pt;
                            r_ob   <= r_pb;
                            r_ost  <= r_pst;
                            r_ofin <= 1'b0;
                        end
                        r_pv   <= 1'b1;
                        r_pn   <= to6(r_ip);
                        r_pt   <= to6(r_if);
                        r_pb   <= to6(r_is);
                        r_pst  <= ST_OK;
                        r_nres <= r_nres + RES_CNT_W'(1);
                    end
                end
                CMD_DONE: begin
                    if (r_nres == '0) begin
                        r_pv  <= 1'b1;
                        r_pn  <= '0;
                        r_pt  <= '0;
                        r_pb  <= '0;
                        r_pst <= ST_DEGEN;
                    end
                end
                CMD_FLUSH: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_on    <= r_pn;
                        r_ot    <= r_pt;
                        r_ob    <= r_pb;
                        r_ost   <= r_pst;
                        r_ofin  <= 1'b1;
                        r_pv    <= 1'b0;
                        r_cnt   <= '0;
                        r_depth <= '0;
                    end
                end
                default: r_pv <= r_pv;
            endcase
        end
    end

    assign o_sts.acc_last   = accept && i_s_tlast;
    assign o_sts.ovf        = r_cnt > CW'(MAX_VERTICES);
    assign o_sts.few        = r_cnt < CW'(3);
    assign o_sts.scan_last  = r_i == cnt_m1;
    assign o_sts.flat       = r_upy == r_loy;
    assign o_sts.tri3       = r_cnt == CW'(3);
    assign o_sts.merge_last = r_k == cnt_m1;
    assign o_sts.deep       = r_depth >= DW'(2);
    assign o_sts.ok         = r_ok;
    assign o_sts.same       = r_same;
    assign o_sts.empty      = r_depth == '0;
    assign o_sts.p_last     = r_p == cnt_m1;
    assign o_sts.stall      = stall;
    assign o_sts.out_free   = out_free;

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_ofin;
    assign o_m_tdata  = {4'b0, r_ost, r_ob, r_ot, r_on};

endmodule
`default_nettype wire
